// ----- hw/rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps

package pfa_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam logic RegRadius = 1'b0;
  localparam logic RegGain   = 1'b1;

  localparam logic [13:0] RadiusReset = 14'd1000;
  localparam logic [3:0]  GainReset   = 4'd2;

  // Obstacle kinds that repel
  localparam logic [2:0] KindSomeRobot = 3'd2;
  localparam logic [2:0] KindOpponent  = 3'd3;
  localparam logic [2:0] KindTeammate  = 3'd4;

  // Bit-serial unit lengths
  localparam int SqrtSteps = 16;
  localparam int DivSteps  = 34;
  localparam int SqrtCntW  = $clog2(SqrtSteps);
  localparam int DivCntW   = $clog2(DivSteps);

  typedef struct packed {
    logic signed [15:0] obstacle_x;
    logic signed [15:0] obstacle_y;
    logic [2:0]         obstacle_kind;
    logic signed [15:0] target_x;
    logic signed [15:0] target_y;
    logic               last;
  } in_t;

  typedef struct packed {
    logic signed [19:0] adjusted_x;
    logic signed [19:0] adjusted_y;
  } out_t;

  typedef struct packed {
    logic [13:0] influence_radius;
    logic [3:0]  repel_gain;
  } cfg_t;

endpackage

// ----- hw/rtl/pfa_regs.sv -----
`timescale 1ns / 1ps

module pfa_regs import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.influence_radius <= RadiusReset;
      cfg_q.repel_gain       <= GainReset;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegRadius: cfg_q.influence_radius <= pwdata[13:0];
        RegGain:   cfg_q.repel_gain       <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegRadius: prdata = {18'd0, cfg_q.influence_radius};
      RegGain:   prdata = {28'd0, cfg_q.repel_gain};
      default:   prdata = 32'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/pfa_isqrt.sv -----
`timescale 1ns / 1ps

module pfa_isqrt import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [15:0] root_o
);

  logic                busy_q;
  logic                done_q;
  logic [SqrtCntW-1:0] cnt_q;
  logic [31:0]         val_q;
  logic [16:0]         rem_q;
  logic [15:0]         root_q;
  logic [18:0]         rem_sh;
  logic [18:0]         trial;
  logic                fits;
  logic [18:0]         rem_new;

  // Bring down two radicand bits, try root*4+1; the remainder can reach 2*root
  assign rem_sh  = {rem_q, val_q[31:30]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign fits    = rem_sh >= trial;
  assign rem_new = fits ? rem_sh - trial : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= SqrtCntW'(SqrtSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      val_q  <= {val_q[29:0], 2'b00};
      rem_q  <= rem_new[16:0];
      root_q <= {root_q[14:0], fits};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ----- hw/rtl/pfa_div.sv -----
`timescale 1ns / 1ps

module pfa_div import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] dividend_i,
  input  logic [13:0] divisor_i,
  output logic        done_o,
  output logic [33:0] quot_o
);

  logic               busy_q;
  logic               done_q;
  logic [DivCntW-1:0] cnt_q;
  logic [33:0]        quo_q;
  logic [13:0]        rem_q;
  logic [13:0]        div_q;
  logic [14:0]        rem_sh;
  logic               fits;
  logic [14:0]        rem_new;

  // Restoring step: shift in next dividend bit, subtract when it fits
  assign rem_sh  = {rem_q, quo_q[33]};
  assign fits    = rem_sh >= {1'b0, div_q};
  assign rem_new = fits ? rem_sh - {1'b0, div_q} : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DivCntW'(DivSteps - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[32:0], fits};
      rem_q <= rem_new[13:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ----- hw/rtl/potential_field_avoidance_top.sv -----
`timescale 1ns / 1ps

// Potential-field obstacle repulsion. Feed one obstacle per input transaction
// (robot-relative position in mm, kind, target, last flag). Robot kinds (some
// robot, opponent, teammate) at a floored distance d with 0 < d < radius add
// -pos*(radius-d)*gain/d, truncated toward zero, to a 24-bit saturating 2-D sum.
// The transaction with last set emits one output transaction, target plus sum
// saturated to 20 bits, and clears the sum; send an empty list as one
// non-robot item with last set. The block takes one obstacle at a time and
// drops in_ready_o while it works: a non-robot obstacle goes straight to the
// final state, a robot obstacle outside the radius waits on the bit-serial
// square root (16 steps), and a repelling one also runs two passes of the
// bit-serial divider (34 steps each), with one 17x18 multiplier shared for
// the squares, the scale and both numerators. A result waiting on the output
// does not block the next input transaction; only a second last item stalls
// in its final state until the output frees up.
// Configuration: influence_radius at address 0, repel_gain at address 4.

module potential_field_avoidance_top import pfa_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_SQX    = 10'b00_0000_0010,
    S_SQY    = 10'b00_0000_0100,
    S_ROOT   = 10'b00_0000_1000,
    S_SCALE  = 10'b00_0001_0000,
    S_MULX   = 10'b00_0010_0000,
    S_DIVX   = 10'b00_0100_0000,
    S_MULY   = 10'b00_1000_0000,
    S_DIVY   = 10'b01_0000_0000,
    S_FINISH = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  cfg_t cfg;

  // Captured item
  logic [16:0]        ax_q, ay_q;     // magnitudes of the obstacle position
  logic               xneg_q, yneg_q;
  logic signed [15:0] tx_q, ty_q;
  logic               last_q;

  logic [31:0]        sq_q;
  logic [15:0]        d_q;
  logic [17:0]        scale_q;
  logic signed [23:0] sum_x_q, sum_y_q;

  out_t out_q;
  logic out_valid_q;

  // Shared multiplier
  logic [16:0] mul_a;
  logic [17:0] mul_b;
  logic [34:0] mul_p;

  logic        sqrt_start, sqrt_done;
  logic [31:0] sqrt_val;
  logic [15:0] sqrt_root;
  logic        div_start, div_done;
  logic [33:0] div_quot;

  logic        accept;
  logic        in_range;
  logic        emit;
  out_t        adj;
  logic [16:0] in_x_ext, in_y_ext;

  function automatic logic signed [23:0] sat_add(logic signed [23:0] s,
                                                 logic [33:0] q, logic neg);
    logic signed [35:0] term;
    logic signed [35:0] acc;
    begin
      term = neg ? $signed({2'b00, q}) : -$signed({2'b00, q});
      acc  = 36'(s) + term;
      if (acc > 36'sd8388607) begin
        sat_add = 24'sd8388607;
      end else if (acc < -36'sd8388608) begin
        sat_add = -24'sd8388608;
      end else begin
        sat_add = acc[23:0];
      end
    end
  endfunction

  function automatic logic signed [19:0] sat_out(logic signed [15:0] t,
                                                 logic signed [23:0] s);
    logic signed [24:0] acc;
    begin
      acc = 25'(t) + 25'(s);
      if (acc > 25'sd524287) begin
        sat_out = 20'sd524287;
      end else if (acc < -25'sd524288) begin
        sat_out = -20'sd524288;
      end else begin
        sat_out = acc[19:0];
      end
    end
  endfunction

  pfa_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pfa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (sqrt_val),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  pfa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mul_p[33:0]),
    .divisor_i  (d_q[13:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign in_x_ext = {in_data_i.obstacle_x[15], in_data_i.obstacle_x};
  assign in_y_ext = {in_data_i.obstacle_y[15], in_data_i.obstacle_y};

  // Route the shared multiplier by sequencer step
  always_comb begin
    unique case (state_q)
      S_SQX: begin
        mul_a = ax_q;
        mul_b = {1'b0, ax_q};
      end
      S_SQY: begin
        mul_a = ay_q;
        mul_b = {1'b0, ay_q};
      end
      S_SCALE: begin
        mul_a = {3'b000, cfg.influence_radius - d_q[13:0]};
        mul_b = {14'd0, cfg.repel_gain};
      end
      S_MULX: begin
        mul_a = ax_q;
        mul_b = scale_q;
      end
      S_MULY: begin
        mul_a = ay_q;
        mul_b = scale_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = 35'(mul_a) * 35'(mul_b);

  // Start the root as the second square lands; start a divide off each numerator
  assign sqrt_start = (state_q == S_SQY);
  assign sqrt_val   = sq_q + mul_p[31:0];
  assign div_start  = (state_q == S_MULX) || (state_q == S_MULY);

  assign in_range = (sqrt_root != 16'd0) && (sqrt_root < {2'b00, cfg.influence_radius});

  // Emit on a last item once the output register is free
  assign emit = (state_q == S_FINISH) && last_q && (!out_valid_q || out_ready_i);

  assign adj.adjusted_x = sat_out(tx_q, sum_x_q);
  assign adj.adjusted_y = sat_out(ty_q, sum_y_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_FINISH;
          if ((in_data_i.obstacle_kind == KindSomeRobot) ||
              (in_data_i.obstacle_kind == KindOpponent) ||
              (in_data_i.obstacle_kind == KindTeammate)) begin
            state_d = S_SQX;
          end
        end
      end
      S_SQX:   state_d = S_SQY;
      S_SQY:   state_d = S_ROOT;
      S_ROOT: begin
        if (sqrt_done) begin
          state_d = in_range ? S_SCALE : S_FINISH;
        end
      end
      S_SCALE: state_d = S_MULX;
      S_MULX:  state_d = S_DIVX;
      S_DIVX: begin
        if (div_done) begin
          state_d = S_MULY;
        end
      end
      S_MULY:  state_d = S_DIVY;
      S_DIVY: begin
        if (div_done) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!last_q || emit) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control: state, sums and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == S_DIVX) && div_done) begin
        sum_x_q <= sat_add(sum_x_q, div_quot, xneg_q);
      end
      if ((state_q == S_DIVY) && div_done) begin
        sum_y_q <= sat_add(sum_y_q, div_quot, yneg_q);
      end
      if (emit) begin
        sum_x_q     <= '0;
        sum_y_q     <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers: hold the item and intermediate results
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q    <= in_data_i.obstacle_x[15] ? 17'(-in_x_ext) : in_x_ext;
      ay_q    <= in_data_i.obstacle_y[15] ? 17'(-in_y_ext) : in_y_ext;
      xneg_q  <= in_data_i.obstacle_x[15];
      yneg_q  <= in_data_i.obstacle_y[15];
      tx_q    <= in_data_i.target_x;
      ty_q    <= in_data_i.target_y;
      last_q  <= in_data_i.last;
    end
    if (state_q == S_SQX) begin
      sq_q    <= mul_p[31:0];
    end
    if ((state_q == S_ROOT) && sqrt_done) begin
      d_q <= sqrt_root;
    end
    if (state_q == S_SCALE) begin
      scale_q <= mul_p[17:0];
    end
    if (emit) begin
      out_q <= adj;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
